FILE: hdl/cpmu_pkg.sv
// ----------------------------------------------------------------------------
// cpmu_pkg: shared types and arithmetic for the contagion pool block
// Holds op codes, the decoded command, the sequencer states and the
// Q16.16 rounding and saturation helpers.
// ----------------------------------------------------------------------------
package cpmu_pkg;

	localparam int ROUTE_SLOTS = 2;
	localparam int Q_ONE       = 65536;
	localparam int DECAY_W     = 17;
	localparam int GROUPS_W    = 5;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_ZERO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_ONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPS_ZERO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUPS_ONE  = 2'd3;

	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_DEPOSIT = 3'd1,
		OP_POPUL   = 3'd2,
		OP_CORRECT = 3'd3,
		OP_END     = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	// decoded item as it travels from the front end to the back end
	typedef struct packed {
		logic              known;
		op_t               op;
		logic [1:0]        member;
		logic [3:0]        grp0;
		logic [3:0]        grp1;
		logic signed [31:0] amount;
		logic signed [31:0] weight;
		logic              mload_ok;
		logic              mroute;
		logic [3:0]        msink;
		logic [3:0]        msource;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] total;
		logic              sat;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ITEM_RD,
		ST_ITEM_EX,
		ST_ITEM_WR,
		ST_POP_MUL,
		ST_POP_ADD,
		ST_END_ROUTE,
		ST_DOT,
		ST_DRAIN,
		ST_FAC,
		ST_KEEP,
		ST_UPD,
		ST_RATE_BEGIN,
		ST_RATE_RD,
		ST_DIV_INIT,
		ST_DIV,
		ST_RATE_WR,
		ST_RESULT
	} bk_state_t;

	// Q16.16 product rounded: add half, floor
	function automatic logic signed [47:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd32768;
		return $signed(t[63:16]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return $signed(v[31:0]);
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

endpackage

FILE: hdl/contagion_pool_mixing_update.sv
// End of step, per route: dot products and updates for each of the G groups in
//   use, then the serial divider for each group when population is positive.
// Throughput: one item at a time in the back end; a two-entry command queue
//   and a two-entry result queue decouple the ports. Reset clears all pools.
// ----------------------------------------------------------------------------
// contagion_pool_mixing_update: per-route contagion pools with mixing
// Configuration registers, front-end classification and back-end execution.
// ----------------------------------------------------------------------------
module contagion_pool_mixing_update #(
	parameter int ROUTE_COUNT = 2,
	parameter int MAX_GROUPS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          op,
	input  logic [1:0]          member_mask,
	input  logic [3:0]          group_on_zero,
	input  logic [3:0]          group_on_one,
	input  logic signed [31:0]  amount,
	input  logic signed [31:0]  weight,
	input  logic                matrix_route,
	input  logic [3:0]          matrix_sink,
	input  logic [3:0]          matrix_source,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  total_rate,
	output logic                saturated
);
	import cpmu_pkg::*;

	localparam int GCW = $clog2(MAX_GROUPS + 1);

	logic [DECAY_W-1:0]  decay_q  [ROUTE_SLOTS];
	logic [GROUPS_W-1:0] groups_q [ROUTE_SLOTS];
	logic [ROUTE_COUNT-1:0][GCW-1:0] gn;
	logic [ROUTE_COUNT-1:0][16:0]    keep;
	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q[0]  <= DECAY_W'(Q_ONE);
			decay_q[1]  <= DECAY_W'(Q_ONE);
			groups_q[0] <= GROUPS_W'(1);
			groups_q[1] <= GROUPS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DECAY_ZERO:  decay_q[0]  <= cfg_data;
				REG_DECAY_ONE:   decay_q[1]  <= cfg_data;
				REG_GROUPS_ZERO: groups_q[0] <= cfg_data[GROUPS_W-1:0];
				REG_GROUPS_ONE:  groups_q[1] <= cfg_data[GROUPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp groups in use and form the retained fraction
	always_comb begin
		for (int r = 0; r < ROUTE_COUNT; r++) begin
			if (groups_q[r] == '0)
				gn[r] = GCW'(1);
			else if (int'(groups_q[r]) > MAX_GROUPS)
				gn[r] = GCW'(MAX_GROUPS);
			else
				gn[r] = GCW'(groups_q[r]);
			keep[r] = (int'(decay_q[r]) >= Q_ONE) ? 17'd0 : 17'(Q_ONE - int'(decay_q[r]));
		end
	end

	cpmu_front #(.ROUTE_COUNT(ROUTE_COUNT), .MAX_GROUPS(MAX_GROUPS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.member_mask  (member_mask),
		.group_on_zero(group_on_zero),
		.group_on_one (group_on_one),
		.amount       (amount),
		.weight       (weight),
		.matrix_route (matrix_route),
		.matrix_sink  (matrix_sink),
		.matrix_source(matrix_source),
		.gn           (gn),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	cpmu_back #(.ROUTE_COUNT(ROUTE_COUNT), .MAX_GROUPS(MAX_GROUPS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.gn       (gn),
		.keep     (keep),
		.res_empty(empty),
		.res_pop  (pop),
		.res_total(total_rate),
		.res_sat  (saturated)
	);

endmodule

FILE: hdl/cpmu_ram.sv
// ----------------------------------------------------------------------------
// cpmu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cpmu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/cpmu_front.sv
// ----------------------------------------------------------------------------
// cpmu_front: item intake and classification
// Decodes the op, resolves route membership and matrix load range, and
// queues the decoded command for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module cpmu_front #(
	parameter int ROUTE_COUNT = 2,
	parameter int MAX_GROUPS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          op,
	input  logic [1:0]          member_mask,
	input  logic [3:0]          group_on_zero,
	input  logic [3:0]          group_on_one,
	input  logic signed [31:0]  amount,
	input  logic signed [31:0]  weight,
	input  logic                matrix_route,
	input  logic [3:0]          matrix_sink,
	input  logic [3:0]          matrix_source,
	input  logic [ROUTE_COUNT-1:0][$clog2(MAX_GROUPS+1)-1:0] gn,
	output logic                cmd_valid,
	output cpmu_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);
	import cpmu_pkg::*;

	cmd_t       dec;
	cmd_t       q_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	// classify the incoming item
	always_comb begin
		dec          = '0;
		dec.known    = (op <= 3'(OP_QUERY));
		dec.op       = op_t'(op);
		dec.grp0     = group_on_zero;
		dec.grp1     = group_on_one;
		dec.amount   = amount;
		dec.weight   = weight;
		dec.mroute   = matrix_route;
		dec.msink    = matrix_sink;
		dec.msource  = matrix_source;
		dec.mload_ok = (int'(matrix_route) < ROUTE_COUNT) &&
			(int'(matrix_sink) < MAX_GROUPS) && (int'(matrix_source) < MAX_GROUPS);
		for (int r = 0; r < ROUTE_COUNT; r++) begin
			dec.member[r] = member_mask[r] &&
				(int'((r == 0) ? group_on_zero : group_on_one) < int'(gn[r]));
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;

	// command queue storage
	always_ff @(posedge clk) begin
		if (wr)
			q_q[wptr_q] <= dec;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr)
				wptr_q <= ~wptr_q;
			if (rd)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

FILE: hdl/cpmu_back.sv
// ----------------------------------------------------------------------------
// cpmu_back: command execution
// Sequencer over the pool memories, a shared registered multiplier, the
// dot product pipeline, a bit-serial rate divider and the result queue.
// ----------------------------------------------------------------------------
module cpmu_back #(
	parameter int ROUTE_COUNT = 2,
	parameter int MAX_GROUPS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  cpmu_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic [ROUTE_COUNT-1:0][$clog2(MAX_GROUPS+1)-1:0] gn,
	input  logic [ROUTE_COUNT-1:0][16:0] keep,
	output logic                res_empty,
	input  logic                res_pop,
	output logic signed [31:0]  res_total,
	output logic                res_sat
);
	import cpmu_pkg::*;

	localparam int RW   = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;
	localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW  = $clog2(MAX_GROUPS + 1);
	localparam int PDEP = ROUTE_COUNT * MAX_GROUPS;
	localparam int MDEP = ROUTE_COUNT * MAX_GROUPS * MAX_GROUPS;
	localparam int PAW  = (PDEP > 1) ? $clog2(PDEP) : 1;
	localparam int MAW  = (MDEP > 1) ? $clog2(MDEP) : 1;
	localparam int DIVN = 48;

	function automatic logic [PAW-1:0] paddr(input logic [RW-1:0] r, input logic [GW-1:0] g);
		return PAW'(int'(r) * MAX_GROUPS + int'(g));
	endfunction

	bk_state_t state_q, state_d;

	cmd_t                    cmd_q;
	logic [RW-1:0]           r_q;
	logic [GCW-1:0]          s_q;
	logic [GCW-1:0]          c_q;
	logic                    flag_q;
	logic signed [31:0]      total_q;
	logic signed [55:0]      acc_q;
	logic signed [31:0]      cur_q;
	logic signed [31:0]      add_q;
	logic signed [63:0]      mul_q;
	logic                    rd_v_s1;
	logic                    mul_v_s2;
	logic signed [31:0]      pop_q [ROUTE_COUNT];
	logic [ROUTE_COUNT-1:0][MAX_GROUPS-1:0] shed_vld_q, cur_vld_q, rate_vld_q;
	logic                    shed_ok_s1, cur_ok_s1, rate_ok_s1;
	logic                    neg_q;
	logic [31:0]             rem_q;
	logic [DIVN-1:0]         quo_q;
	logic [5:0]              div_cnt_q;

	// result queue
	res_t                    rq_q [2];
	logic                    rq_wptr_q, rq_rptr_q;
	logic [1:0]              rq_cnt_q;
	logic                    res_full;
	logic                    res_push;

	// memory and datapath controls
	logic                    mat_we;
	logic [MAW-1:0]          mat_waddr, mat_raddr;
	logic [31:0]             mat_rdata;
	logic [RW-1:0]           prd_r, pwr_r;
	logic [GW-1:0]           prd_g, pwr_g;
	logic signed [31:0]      pwd;
	logic                    shed_we, cur_we, rate_we, clr_en;
	logic [31:0]             shed_rdata, cur_rdata, rate_rdata;
	logic signed [32:0]      mul_a, mul_b;
	logic signed [63:0]      mul_w;

	// derived values
	logic [3:0]              item_grp4;
	logic [GW-1:0]           item_grp;
	logic signed [31:0]      d_shed, d_cur, d_rate, item_d;
	logic signed [63:0]      dep_sum, tot_sum, upd_sum, rate_val;
	logic signed [47:0]      q_rnd;
	logic signed [31:0]      dot_sat;
	logic                    last_route, s_last, c_last;
	logic [GCW-1:0]          gn_r;
	logic signed [31:0]      pop_r;
	logic [32:0]             trial;
	logic                    ge;
	logic [32:0]             cur_mag;
	logic signed [63:0]      pop_delta_sum [ROUTE_COUNT];

	assign item_grp4  = (int'(r_q) == 0) ? cmd_q.grp0 : cmd_q.grp1;
	assign item_grp   = GW'(item_grp4);
	assign d_shed     = shed_ok_s1 ? $signed(shed_rdata) : 32'sd0;
	assign d_cur      = cur_ok_s1 ? $signed(cur_rdata) : 32'sd0;
	assign d_rate     = rate_ok_s1 ? $signed(rate_rdata) : 32'sd0;
	assign item_d     = (cmd_q.op == OP_QUERY) ? d_rate : d_shed;
	assign dep_sum    = 64'(item_d) + 64'(cmd_q.amount);
	assign tot_sum    = 64'(total_q) + 64'(item_d);
	assign q_rnd      = qround(mul_q);
	assign upd_sum    = 64'(q_rnd) + 64'(add_q);
	assign dot_sat    = sat32(64'(acc_q));
	assign gn_r       = gn[r_q];
	assign pop_r      = pop_q[r_q];
	assign last_route = (int'(r_q) == ROUTE_COUNT - 1);
	assign s_last     = (s_q == gn_r - GCW'(1));
	assign c_last     = (c_q == gn_r - GCW'(1));
	assign mul_w      = mul_a * mul_b;
	assign cur_mag    = d_cur[31] ? 33'(-64'(d_cur)) : 33'(d_cur);
	assign res_full   = (rq_cnt_q == 2'd2);

	// divider step: shift in one numerator bit, subtract when it fits
	assign trial = {rem_q, quo_q[DIVN-1]};
	assign ge    = (trial >= {1'b0, pop_r});

	// rate from the quotient, sign restored
	assign rate_val = neg_q ? -$signed({16'b0, quo_q}) : $signed({16'b0, quo_q});

	always_comb begin
		for (int r = 0; r < ROUTE_COUNT; r++)
			pop_delta_sum[r] = 64'(pop_q[r]) + 64'(q_rnd);
	end

	cpmu_ram #(.WIDTH(32), .DEPTH(MDEP)) u_matrix (
		.clk  (clk),
		.we   (mat_we),
		.waddr(mat_waddr),
		.wdata(cmd.amount),
		.raddr(mat_raddr),
		.rdata(mat_rdata)
	);

	cpmu_ram #(.WIDTH(32), .DEPTH(PDEP)) u_shed (
		.clk  (clk),
		.we   (shed_we),
		.waddr(paddr(pwr_r, pwr_g)),
		.wdata(pwd),
		.raddr(paddr(prd_r, prd_g)),
		.rdata(shed_rdata)
	);

	cpmu_ram #(.WIDTH(32), .DEPTH(PDEP)) u_current (
		.clk  (clk),
		.we   (cur_we),
		.waddr(paddr(pwr_r, pwr_g)),
		.wdata(pwd),
		.raddr(paddr(prd_r, prd_g)),
		.rdata(cur_rdata)
	);

	cpmu_ram #(.WIDTH(32), .DEPTH(PDEP)) u_rate (
		.clk  (clk),
		.we   (rate_we),
		.waddr(paddr(pwr_r, pwr_g)),
		.wdata(pwd),
		.raddr(paddr(prd_r, prd_g)),
		.rdata(rate_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_full) begin
					if (!cmd.known)
						state_d = ST_RESULT;
					else begin
						unique case (cmd.op)
							OP_LOAD:    state_d = ST_RESULT;
							OP_POPUL:   state_d = ST_POP_MUL;
							OP_END:     state_d = ST_END_ROUTE;
							default:    state_d = ST_ITEM_RD;
						endcase
					end
				end
			end
			ST_ITEM_RD: begin
				if (cmd_q.member[r_q])
					state_d = ST_ITEM_EX;
				else if (last_route)
					state_d = ST_RESULT;
			end
			ST_ITEM_EX: begin
				if (cmd_q.op == OP_CORRECT)
					state_d = ST_ITEM_WR;
				else if (last_route)
					state_d = ST_RESULT;
				else
					state_d = ST_ITEM_RD;
			end
			ST_ITEM_WR:   state_d = last_route ? ST_RESULT : ST_ITEM_RD;
			ST_POP_MUL:   state_d = ST_POP_ADD;
			ST_POP_ADD:   state_d = ST_RESULT;
			ST_END_ROUTE: state_d = ST_DOT;
			ST_DOT:       state_d = c_last ? ST_DRAIN : ST_DOT;
			ST_DRAIN:     state_d = (!rd_v_s1 && !mul_v_s2) ? ST_FAC : ST_DRAIN;
			ST_FAC:       state_d = ST_KEEP;
			ST_KEEP:      state_d = ST_UPD;
			ST_UPD:       state_d = s_last ? ST_RATE_BEGIN : ST_DOT;
			ST_RATE_BEGIN: begin
				if (pop_r > 32'sd0)
					state_d = ST_RATE_RD;
				else
					state_d = last_route ? ST_RESULT : ST_END_ROUTE;
			end
			ST_RATE_RD:   state_d = ST_DIV_INIT;
			ST_DIV_INIT:  state_d = ST_DIV;
			ST_DIV:       state_d = (int'(div_cnt_q) == DIVN - 1) ? ST_RATE_WR : ST_DIV;
			ST_RATE_WR: begin
				if (!s_last)
					state_d = ST_RATE_RD;
				else
					state_d = last_route ? ST_RESULT : ST_END_ROUTE;
			end
			ST_RESULT:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory, multiplier and handshake controls
	always_comb begin
		cmd_pop   = 1'b0;
		mat_we    = 1'b0;
		mat_waddr = MAW'((int'(cmd.mroute) * MAX_GROUPS + int'(cmd.msink)) * MAX_GROUPS
			+ int'(cmd.msource));
		mat_raddr = MAW'((int'(r_q) * MAX_GROUPS + int'(s_q)) * MAX_GROUPS + int'(c_q));
		prd_r     = r_q;
		prd_g     = item_grp;
		pwr_r     = r_q;
		pwr_g     = item_grp;
		pwd       = sat32(dep_sum);
		shed_we   = 1'b0;
		cur_we    = 1'b0;
		rate_we   = 1'b0;
		clr_en    = 1'b0;
		res_push  = 1'b0;
		mul_a     = {cmd_q.amount[31], cmd_q.amount};
		mul_b     = {cmd_q.weight[31], cmd_q.weight};
		unique case (state_q)
			ST_IDLE: begin
				cmd_pop = cmd_valid && !res_full;
				mat_we  = cmd_pop && cmd.known && (cmd.op == OP_LOAD) && cmd.mload_ok;
			end
			ST_ITEM_EX: begin
				shed_we = (cmd_q.op == OP_DEPOSIT);
				mul_a   = {item_d[31], item_d};
				mul_b   = {cmd_q.amount[31], cmd_q.amount};
			end
			ST_ITEM_WR: begin
				pwd     = sat32(64'(q_rnd));
				shed_we = 1'b1;
			end
			ST_DOT: begin
				prd_g = GW'(c_q);
			end
			ST_DRAIN: begin
				prd_g = GW'(s_q);
			end
			ST_FAC: begin
				mul_a = {dot_sat[31], dot_sat};
				mul_b = {cmd_q.amount[31], cmd_q.amount};
			end
			ST_KEEP: begin
				mul_a = {cur_q[31], cur_q};
				mul_b = $signed({16'b0, keep[r_q]});
			end
			ST_UPD: begin
				pwr_g  = GW'(s_q);
				pwd    = sat32(upd_sum);
				cur_we = 1'b1;
			end
			ST_RATE_BEGIN: begin
				clr_en = 1'b1;
			end
			ST_RATE_RD: begin
				prd_g = GW'(s_q);
			end
			ST_RATE_WR: begin
				pwr_g   = GW'(s_q);
				pwd     = sat32(rate_val);
				rate_we = 1'b1;
			end
			ST_RESULT: begin
				res_push = 1'b1;
			end
			default: begin
			end
		endcase
		// dot pipeline owns the multiplier whenever read data is arriving
		if (rd_v_s1) begin
			mul_a = {mat_rdata[31], mat_rdata};
			mul_b = {d_shed[31], d_shed};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_v_s1    <= 1'b0;
			mul_v_s2   <= 1'b0;
			shed_vld_q <= '0;
			cur_vld_q  <= '0;
			rate_vld_q <= '0;
			for (int r = 0; r < ROUTE_COUNT; r++)
				pop_q[r] <= 32'sd0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= (state_q == ST_DOT);
			mul_v_s2 <= rd_v_s1;
			if (shed_we)
				shed_vld_q[pwr_r][pwr_g] <= 1'b1;
			if (cur_we)
				cur_vld_q[pwr_r][pwr_g] <= 1'b1;
			if (rate_we)
				rate_vld_q[pwr_r][pwr_g] <= 1'b1;
			// end of step clears shed and stale rates of the route
			if (clr_en) begin
				shed_vld_q[r_q] <= '0;
				rate_vld_q[r_q] <= '0;
			end
			if (state_q == ST_POP_ADD) begin
				for (int r = 0; r < ROUTE_COUNT; r++)
					if (cmd_q.member[r])
						pop_q[r] <= sat32(pop_delta_sum[r]);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q      <= mul_w;
		shed_ok_s1 <= shed_vld_q[prd_r][prd_g];
		cur_ok_s1  <= cur_vld_q[prd_r][prd_g];
		rate_ok_s1 <= rate_vld_q[prd_r][prd_g];
		if (mul_v_s2)
			acc_q <= acc_q + 56'(q_rnd);
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd;
				flag_q  <= 1'b0;
				total_q <= 32'sd0;
				r_q     <= '0;
			end
			ST_ITEM_RD: begin
				if (!cmd_q.member[r_q] && !last_route)
					r_q <= r_q + RW'(1);
			end
			ST_ITEM_EX: begin
				if (cmd_q.op == OP_DEPOSIT)
					flag_q <= flag_q | ovf32(dep_sum);
				if (cmd_q.op == OP_QUERY) begin
					flag_q  <= flag_q | ovf32(tot_sum);
					total_q <= sat32(tot_sum);
				end
				if (cmd_q.op != OP_CORRECT && !last_route)
					r_q <= r_q + RW'(1);
			end
			ST_ITEM_WR: begin
				flag_q <= flag_q | ovf32(64'(q_rnd));
				if (!last_route)
					r_q <= r_q + RW'(1);
			end
			ST_POP_ADD: begin
				for (int r = 0; r < ROUTE_COUNT; r++)
					if (cmd_q.member[r] && ovf32(pop_delta_sum[r]))
						flag_q <= 1'b1;
			end
			ST_END_ROUTE: begin
				s_q   <= '0;
				c_q   <= '0;
				acc_q <= '0;
			end
			ST_DOT: begin
				c_q <= c_q + GCW'(1);
			end
			ST_FAC: begin
				cur_q  <= d_cur;
				flag_q <= flag_q | ovf32(64'(acc_q));
			end
			ST_KEEP: begin
				add_q  <= sat32(64'(q_rnd));
				flag_q <= flag_q | ovf32(64'(q_rnd));
			end
			ST_UPD: begin
				flag_q <= flag_q | ovf32(upd_sum);
				s_q    <= s_q + GCW'(1);
				c_q    <= '0;
				acc_q  <= '0;
			end
			ST_RATE_BEGIN: begin
				s_q <= '0;
				if (!(pop_r > 32'sd0) && !last_route)
					r_q <= r_q + RW'(1);
			end
			ST_DIV_INIT: begin
				neg_q     <= d_cur[31];
				quo_q     <= {cur_mag[31:0], 16'b0};
				rem_q     <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q     <= ge ? 32'(trial - {1'b0, pop_r}) : trial[31:0];
				quo_q     <= {quo_q[DIVN-2:0], ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			ST_RATE_WR: begin
				flag_q <= flag_q | ovf32(rate_val);
				s_q    <= s_q + GCW'(1);
				if (s_last && !last_route)
					r_q <= r_q + RW'(1);
			end
			default: begin
			end
		endcase
	end

	// result queue
	assign res_empty = (rq_cnt_q == 2'd0);
	assign res_total = rq_q[rq_rptr_q].total;
	assign res_sat   = rq_q[rq_rptr_q].sat;

	always_ff @(posedge clk) begin
		if (res_push)
			rq_q[rq_wptr_q] <= '{total: total_q, sat: flag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wptr_q <= 1'b0;
			rq_rptr_q <= 1'b0;
			rq_cnt_q  <= 2'd0;
		end else begin
			if (res_push)
				rq_wptr_q <= ~rq_wptr_q;
			if (res_pop && !res_empty)
				rq_rptr_q <= ~rq_rptr_q;
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(res_pop && !res_empty);
		end
	end

	// a result is only written when the queue had room at command start
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	// factor stage must see a finished dot product
	a_dot_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FAC) |-> (!rd_v_s1 && !mul_v_s2))
		else $error("dot product still in flight at factor stage");

	// products accumulate only in the cycle after read data arrived
	a_mul_follows_rd: assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s2 |-> $past(rd_v_s1))
		else $error("accumulate without a matching read");

	// divider never runs past its bit count
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (int'(div_cnt_q) < DIVN))
		else $error("divider count overrun");

endmodule
